### design/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared codes and constants for the JSON structure checker: status codes,
// context codes, the significant text characters and default sizes.
// ----------------------------------------------------------------------------
package jsc_pkg;

	localparam int DEFAULT_STACK_DEPTH = 64;
	localparam int STATUS_W = 5;
	localparam int CTX_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE        = 5'd0,
		ST_SPACE       = 5'd1,
		ST_ESCAPE      = 5'd2,
		ST_OBJ_BEGIN   = 5'd3,
		ST_OBJ_END     = 5'd4,
		ST_KEY_BEGIN   = 5'd5,
		ST_KEY_END     = 5'd6,
		ST_VALUE_BEGIN = 5'd7,
		ST_VALUE_END   = 5'd8,
		ST_ARR_BEGIN   = 5'd9,
		ST_ARR_END     = 5'd10,
		ST_ELEM_SEP    = 5'd11,
		ST_STR_BEGIN   = 5'd12,
		ST_STR_END     = 5'd13,
		ST_ERR_OBJ     = 5'd14,
		ST_ERR_ARR     = 5'd15,
		ST_ERR_KEY     = 5'd16,
		ST_ERR_VALUE   = 5'd17,
		ST_ERR_OTHER   = 5'd18
	} status_t;

	typedef enum logic [CTX_W-1:0] {
		CX_OBJ   = 3'd0,
		CX_KEY   = 3'd1,
		CX_VALUE = 3'd2,
		CX_ARR   = 3'd3,
		CX_STR   = 3'd4,
		CX_ESC   = 3'd5,
		CX_NONE  = 3'd7
	} ctx_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	function automatic logic is_error(input status_t st);
		return (st == ST_ERR_OBJ) || (st == ST_ERR_ARR) || (st == ST_ERR_KEY) ||
			(st == ST_ERR_VALUE) || (st == ST_ERR_OTHER);
	endfunction

endpackage

### design/jsc_stack_mem.sv
// ----------------------------------------------------------------------------
// jsc_stack_mem
// Context stack storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module jsc_stack_mem #(
	parameter int STACK_DEPTH = jsc_pkg::DEFAULT_STACK_DEPTH,
	parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [jsc_pkg::CTX_W-1:0] wdata,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic [jsc_pkg::CTX_W-1:0] rdata_a,
	output logic [jsc_pkg::CTX_W-1:0] rdata_b
);

	logic [jsc_pkg::CTX_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### design/jsc_ctrl.sv
// ----------------------------------------------------------------------------
// jsc_ctrl
// Per-byte context update: caches the top two stack entries, pushes into the
// stack memory and refills the cache from the memory's read ports on pops.
// ----------------------------------------------------------------------------
module jsc_ctrl #(
	parameter int STACK_DEPTH = jsc_pkg::DEFAULT_STACK_DEPTH,
	parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	parameter int SPW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [7:0]                  text_byte,
	output logic [jsc_pkg::STATUS_W-1:0] res_status,
	output logic [SPW-1:0]              res_depth,
	output logic                        res_complete,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [jsc_pkg::CTX_W-1:0]    mem_wdata,
	output logic [AW-1:0]               mem_raddr_a,
	output logic [AW-1:0]               mem_raddr_b,
	input  logic [jsc_pkg::CTX_W-1:0]    mem_rdata_a,
	input  logic [jsc_pkg::CTX_W-1:0]    mem_rdata_b
);

	typedef enum logic [1:0] {OP_NOP, OP_PUSH, OP_POP1, OP_POP2} op_t;

	jsc_pkg::status_t last_q;
	logic [SPW-1:0]   sp_q;
	jsc_pkg::ctx_t    top_q;
	jsc_pkg::ctx_t    sec_q;

	jsc_pkg::ctx_t    top_c;
	jsc_pkg::ctx_t    under_c;
	jsc_pkg::ctx_t    rd_a;
	jsc_pkg::ctx_t    rd_b;
	jsc_pkg::ctx_t    push_cx;
	jsc_pkg::status_t push_st;
	jsc_pkg::status_t st_n;
	logic             space_c;
	logic             full_c;
	op_t              op;
	logic [SPW-1:0]   sp_n;
	logic [SPW-1:0]   sp_nx;
	logic [SPW:0]     addr_a;
	logic [SPW:0]     addr_b;

	assign rd_a = jsc_pkg::ctx_t'(mem_rdata_a);
	assign rd_b = jsc_pkg::ctx_t'(mem_rdata_b);

	always_comb begin
		top_c = (sp_q == '0) ? jsc_pkg::CX_NONE : top_q;
		under_c = (sp_q < SPW'(2)) ? jsc_pkg::CX_NONE : sec_q;
		full_c = (sp_q == SPW'(STACK_DEPTH));
		op = OP_NOP;
		push_cx = jsc_pkg::CX_OBJ;
		push_st = jsc_pkg::ST_NONE;
		st_n = last_q;
		space_c = 1'b0;

		if (jsc_pkg::is_error(last_q)) begin
			st_n = last_q;
		end else if (top_c == jsc_pkg::CX_ESC) begin
			op = OP_POP1;
			st_n = jsc_pkg::ST_NONE;
		end else if (top_c == jsc_pkg::CX_STR && text_byte != jsc_pkg::CH_QUOTE) begin
			if (text_byte == jsc_pkg::CH_BSLASH) begin
				op = OP_PUSH;
				push_cx = jsc_pkg::CX_ESC;
				push_st = jsc_pkg::ST_ESCAPE;
			end else begin
				st_n = jsc_pkg::ST_NONE;
			end
		end else begin
			case (text_byte)
				jsc_pkg::CH_SPACE: begin
					space_c = 1'b1;
				end
				jsc_pkg::CH_BSLASH: begin
					op = OP_PUSH;
					push_cx = jsc_pkg::CX_ESC;
					push_st = jsc_pkg::ST_ESCAPE;
				end
				jsc_pkg::CH_LBRACE: begin
					if (last_q == jsc_pkg::ST_KEY_BEGIN) begin
						st_n = jsc_pkg::ST_ERR_KEY;
					end else begin
						op = OP_PUSH;
						push_cx = jsc_pkg::CX_OBJ;
						push_st = jsc_pkg::ST_OBJ_BEGIN;
					end
				end
				jsc_pkg::CH_RBRACE: begin
					if (top_c == jsc_pkg::CX_VALUE) begin
						if (under_c == jsc_pkg::CX_OBJ) begin
							op = OP_POP2;
							st_n = jsc_pkg::ST_OBJ_END;
						end else begin
							op = OP_POP1;
							st_n = jsc_pkg::ST_ERR_OBJ;
						end
					end else if (top_c == jsc_pkg::CX_OBJ) begin
						op = OP_POP1;
						st_n = jsc_pkg::ST_OBJ_END;
					end else begin
						st_n = jsc_pkg::ST_ERR_OBJ;
					end
				end
				jsc_pkg::CH_LBRACK: begin
					if (last_q == jsc_pkg::ST_KEY_BEGIN) begin
						st_n = jsc_pkg::ST_ERR_KEY;
					end else begin
						op = OP_PUSH;
						push_cx = jsc_pkg::CX_ARR;
						push_st = jsc_pkg::ST_ARR_BEGIN;
					end
				end
				jsc_pkg::CH_RBRACK: begin
					if (top_c == jsc_pkg::CX_ARR) begin
						op = OP_POP1;
						st_n = jsc_pkg::ST_ARR_END;
					end else begin
						st_n = jsc_pkg::ST_ERR_ARR;
					end
				end
				jsc_pkg::CH_QUOTE: begin
					if (top_c == jsc_pkg::CX_KEY) begin
						op = OP_POP1;
						st_n = jsc_pkg::ST_KEY_END;
					end else if (last_q == jsc_pkg::ST_OBJ_BEGIN ||
						last_q == jsc_pkg::ST_VALUE_END) begin
						op = OP_PUSH;
						push_cx = jsc_pkg::CX_KEY;
						push_st = jsc_pkg::ST_KEY_BEGIN;
					end else if (top_c == jsc_pkg::CX_STR) begin
						op = OP_POP1;
						st_n = jsc_pkg::ST_STR_END;
					end else begin
						op = OP_PUSH;
						push_cx = jsc_pkg::CX_STR;
						push_st = jsc_pkg::ST_STR_BEGIN;
					end
				end
				jsc_pkg::CH_COLON: begin
					if (last_q == jsc_pkg::ST_KEY_BEGIN) begin
						st_n = jsc_pkg::ST_ERR_KEY;
					end else begin
						op = OP_PUSH;
						push_cx = jsc_pkg::CX_VALUE;
						push_st = jsc_pkg::ST_VALUE_BEGIN;
					end
				end
				jsc_pkg::CH_COMMA: begin
					if (top_c == jsc_pkg::CX_VALUE) begin
						op = OP_POP1;
						st_n = jsc_pkg::ST_VALUE_END;
					end else if (top_c == jsc_pkg::CX_ARR) begin
						st_n = jsc_pkg::ST_ELEM_SEP;
					end else begin
						st_n = jsc_pkg::ST_ERR_VALUE;
					end
				end
				default: begin
					st_n = jsc_pkg::ST_NONE;
				end
			endcase
		end

		if (op == OP_PUSH) begin
			if (full_c) begin
				op = OP_NOP;
				st_n = jsc_pkg::ST_ERR_OTHER;
			end else begin
				st_n = push_st;
			end
		end

		case (op)
			OP_PUSH: sp_n = sp_q + SPW'(1);
			OP_POP1: sp_n = sp_q - SPW'(1);
			OP_POP2: sp_n = sp_q - SPW'(2);
			default: sp_n = sp_q;
		endcase
	end

	assign sp_nx = fire ? sp_n : sp_q;
	assign addr_a = {1'b0, sp_nx} - (SPW + 1)'(3);
	assign addr_b = {1'b0, sp_nx} - (SPW + 1)'(4);

	assign mem_we = fire && (op == OP_PUSH);
	assign mem_waddr = sp_q[AW-1:0];
	assign mem_wdata = push_cx;
	assign mem_raddr_a = addr_a[AW-1:0];
	assign mem_raddr_b = addr_b[AW-1:0];

	assign res_status = space_c ? jsc_pkg::ST_SPACE : st_n;
	assign res_depth = sp_n;
	assign res_complete = (sp_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= jsc_pkg::ST_NONE;
			sp_q <= '0;
		end else if (fire) begin
			last_q <= st_n;
			sp_q <= sp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (op)
				OP_PUSH: begin
					top_q <= push_cx;
					sec_q <= top_q;
				end
				OP_POP1: begin
					top_q <= sec_q;
					sec_q <= rd_a;
				end
				OP_POP2: begin
					top_q <= rd_a;
					sec_q <= rd_b;
				end
				default: begin
					top_q <= top_q;
					sec_q <= sec_q;
				end
			endcase
		end
	end

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && jsc_pkg::is_error(last_q) |=> last_q == $past(last_q) && $stable(sp_q))
		else $error("error status not held");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(sp_q) && $stable(last_q))
		else $error("state moved without a beat");

	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		fire && full_c && op == OP_NOP && st_n == jsc_pkg::ST_ERR_OTHER |=>
		sp_q == SPW'(STACK_DEPTH))
		else $error("push onto full stack changed depth");

endmodule

### design/jsc_out_buf.sv
// ----------------------------------------------------------------------------
// jsc_out_buf
// Result register with a skid stage; the input side stalls only when both
// stages hold a beat.
// ----------------------------------------------------------------------------
module jsc_out_buf #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_fire,
	input  logic [W-1:0] in_data,
	output logic         in_full,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic         skid_valid_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] skid_data_q;
	logic         take;

	assign take = out_valid_q && !out_stall;
	assign in_full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !take) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat ahead of the output register");

	a_no_fire_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !in_fire)
		else $error("beat accepted while buffer full");

	a_skid_move: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && take |=> out_valid_q && !skid_valid_q &&
		out_data_q == $past(skid_data_q))
		else $error("skid beat not moved to output");

endmodule

### design/json_structure_checker_top.sv
// ----------------------------------------------------------------------------
// json_structure_checker_top
// Checks the open/close structure of a JSON byte stream against a context
// stack and reports a status code, nesting depth and completion per byte.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-----------------------------
//   byte     | byte_valid / byte_stall        | text_byte[7:0]
//   result   | result_valid / result_stall    | status_code[4:0],
//            |                                | nesting_depth, document_complete
//
// One byte per cycle while byte_stall is low; each result is registered.
// The top two contexts sit in registers, the rest in a registered-read memory
// whose read ports prefetch the two entries below them every cycle.
// Reset clears status and depth; stack contents need no clearing.
// byte_stall rises only when the output register and its skid stage are full.
// ----------------------------------------------------------------------------
module json_structure_checker_top #(
	parameter int STACK_DEPTH = jsc_pkg::DEFAULT_STACK_DEPTH,
	parameter int SPW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [7:0]                  text_byte,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [jsc_pkg::STATUS_W-1:0] status_code,
	output logic [SPW-1:0]              nesting_depth,
	output logic                        document_complete
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RW = jsc_pkg::STATUS_W + SPW + 1;

	logic                         fire;
	logic                         buf_full;
	logic [jsc_pkg::STATUS_W-1:0] res_status;
	logic [SPW-1:0]               res_depth;
	logic                         res_complete;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [jsc_pkg::CTX_W-1:0]    mem_wdata;
	logic [AW-1:0]                mem_raddr_a;
	logic [AW-1:0]                mem_raddr_b;
	logic [jsc_pkg::CTX_W-1:0]    mem_rdata_a;
	logic [jsc_pkg::CTX_W-1:0]    mem_rdata_b;
	logic [RW-1:0]                res_data;
	logic [RW-1:0]                out_data;

	assign byte_stall = buf_full;
	assign fire = byte_valid && !buf_full;
	assign res_data = {res_status, res_depth, res_complete};
	assign {status_code, nesting_depth, document_complete} = out_data;

	jsc_stack_mem #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	jsc_ctrl #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW(AW),
		.SPW(SPW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.text_byte(text_byte),
		.res_status(res_status),
		.res_depth(res_depth),
		.res_complete(res_complete),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	jsc_out_buf #(
		.W(RW)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(fire),
		.in_data(res_data),
		.in_full(buf_full),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data(out_data)
	);

endmodule
